// ----- rtl/tcw_pkg.sv -----
// Shared constants, types and helper functions of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int IDX_W      = 11;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int FG_W       = 4;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_FG  = 1'd1;

    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET = 8'd4;
    localparam logic [FG_W-1:0]   CLEAR_FG_RESET  = 4'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT        = 2'd0,
        ACT_SET_CURSOR = 2'd1,
        ACT_CLEAR      = 2'd2,
        ACT_READ       = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [CHAR_W-1:0]  char_code;
        logic [ROW_W-1:0]   target_row;
        logic [COL_W-1:0]   target_col;
        logic [IDX_W-1:0]   cell_index;
    } t_cmd;

    typedef struct packed {
        logic [ATTR_W-1:0] text_attr;
        logic [FG_W-1:0]   clear_fg;
    } t_cfg;

    // Packed so that the cursor row lands in the lowest bits.
    typedef struct packed {
        logic              scrolled;
        logic [CELL_W-1:0] cell_data;
        logic [IDX_W-1:0]  cursor_index;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [IDX_W-1:0] linear_index(input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col);
        logic [IDX_W+1:0] sum;
        sum = (IDX_W+2)'(row) * (IDX_W+2)'(COLUMNS) + (IDX_W+2)'(col);
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                    input logic [ATTR_W-1:0] attr);
        return {attr, ch};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_seq.sv -----
// Command sequencer: cursor logic, clear and scroll sweeps, and the result register.
`default_nettype none

module tcw_seq import tcw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_ready,
    input  wire t_cmd              i_cmd,
    input  wire t_cfg              i_cfg,
    output t_ram_req               o_ram,
    input  wire logic [CELL_W-1:0] i_rdata,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CLEAR,
        S_SCROLL_PRIME,
        S_SCROLL,
        S_HOLD
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [CELL_W-1:0] r_data, n_data;
    logic              r_scroll, n_scroll;
    logic              r_rd_ok, n_rd_ok;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              finish;
    logic              out_free;
    logic [ROW_W:0]    put_row;
    logic [COL_W:0]    put_col;
    logic [ADDR_W:0]   scroll_src;
    logic [CELL_W-1:0] blank_text;

    assign out_free   = !r_out_valid || i_res_ready;
    assign blank_text = make_cell(CODE_SPACE, i_cfg.text_attr);
    assign scroll_src = {1'b0, r_ptr} + (ADDR_W+1)'(COLUMNS + 1);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_row    = r_row;
        n_col    = r_col;
        n_ptr    = r_ptr;
        n_data   = r_data;
        n_scroll = r_scroll;
        n_rd_ok  = r_rd_ok;
        o_ram    = '0;
        finish   = 1'b0;
        put_row  = {1'b0, r_row};
        put_col  = {1'b0, r_col};

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    n_data   = '0;
                    n_scroll = 1'b0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd.action)
                    ACT_PUT: begin
                        priority if (r_cmd.char_code == CODE_NEWLINE) begin
                            put_row = {1'b0, r_row} + 1'b1;
                            put_col = '0;
                        end else if (r_cmd.char_code == CODE_BACKSPACE) begin
                            put_col     = (r_col != '0) ? {1'b0, r_col} - 1'b1 : '0;
                            o_ram.we    = 1'b1;
                            o_ram.waddr = ADDR_W'(linear_index(r_row, put_col[COL_W-1:0]));
                            o_ram.wdata = blank_text;
                        end else begin
                            put_col     = {1'b0, r_col} + 1'b1;
                            o_ram.we    = 1'b1;
                            o_ram.waddr = ADDR_W'(linear_index(r_row, r_col));
                            o_ram.wdata = make_cell(r_cmd.char_code, i_cfg.text_attr);
                        end
                        if (put_col >= (COL_W+1)'(COLUMNS)) begin
                            put_col = '0;
                            put_row = put_row + 1'b1;
                        end
                        n_col = put_col[COL_W-1:0];
                        if (put_row >= (ROW_W+1)'(ROWS)) begin
                            n_row   = ROW_W'(ROWS - 1);
                            n_ptr   = '0;
                            n_state = S_SCROLL_PRIME;
                        end else begin
                            n_row  = put_row[ROW_W-1:0];
                            finish = 1'b1;
                        end
                    end
                    ACT_SET_CURSOR: begin
                        n_row  = (r_cmd.target_row >= ROW_W'(ROWS)) ?
                                 ROW_W'(ROWS - 1) : r_cmd.target_row;
                        n_col  = (r_cmd.target_col >= COL_W'(COLUMNS)) ?
                                 COL_W'(COLUMNS - 1) : r_cmd.target_col;
                        finish = 1'b1;
                    end
                    ACT_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_ptr   = '0;
                        n_state = S_CLEAR;
                    end
                    ACT_READ: begin
                        n_rd_ok     = r_cmd.cell_index < IDX_W'(CELL_COUNT);
                        o_ram.re    = n_rd_ok;
                        o_ram.raddr = r_cmd.cell_index[ADDR_W-1:0];
                        n_state     = S_READ;
                    end
                endcase
            end
            S_READ: begin
                n_data = r_rd_ok ? i_rdata : '0;
                finish = 1'b1;
            end
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr;
                o_ram.wdata = make_cell(CODE_SPACE, ATTR_W'(i_cfg.clear_fg));
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    finish = 1'b1;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_SCROLL_PRIME: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = ADDR_W'(COLUMNS);
                n_state     = S_SCROLL;
            end
            S_SCROLL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr;
                o_ram.wdata = (r_ptr >= ADDR_W'(CELL_COUNT - COLUMNS)) ? blank_text : i_rdata;
                o_ram.re    = scroll_src < (ADDR_W+1)'(CELL_COUNT);
                o_ram.raddr = scroll_src[ADDR_W-1:0];
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_scroll = 1'b1;
                    finish   = 1'b1;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_HOLD: begin
                finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out       = r_out;
        n_out_valid = i_res_ready ? 1'b0 : r_out_valid;
        if (finish) begin
            if (out_free) begin
                n_out.cursor_row   = n_row;
                n_out.cursor_col   = n_col;
                n_out.cursor_index = linear_index(n_row, n_col);
                n_out.cell_data    = n_data;
                n_out.scrolled     = n_scroll;
                n_out_valid        = 1'b1;
                n_state            = S_IDLE;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_row       <= n_row;
            r_col       <= n_col;
            r_ptr       <= n_ptr;
            r_data      <= n_data;
            r_scroll    <= n_scroll;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// Put and set-cursor give a registered result from the execute state; read passes through the
// read state as well. A new transfer is taken only in idle, after the result is registered.
// Clear sweeps the screen memory at one cell a cycle.
// A put that scrolls primes a read, then copies and blanks through the memory port.
// Synchronous active-low reset homes the cursor, empties the result register and
// restores both registers; the screen memory is not cleared and reads are valid after a clear.
`default_nettype none

module text_console_writer import tcw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // char_code[7:0], target_row[12:8], target_col[19:13], cell_index[30:20], zero[31]
    input  wire logic [S_DATA_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  wire logic [ACT_W-1:0]      s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // cursor_row[4:0], cursor_col[11:5], cursor_index[22:12], cell_data[38:23], scrolled[39]
    output logic [M_DATA_W-1:0]        m_axis_tdata
);

    logic [ATTR_W-1:0] r_text_attr;
    logic [FG_W-1:0]   r_clear_fg;
    t_cfg              cfg;
    t_cmd              cmd;
    t_ram_req          ram_req;
    t_result           res;
    logic [CELL_W-1:0] ram_rdata;
    logic              seq_ready;
    logic              res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= TEXT_ATTR_RESET;
            r_clear_fg  <= CLEAR_FG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEXT_ATTR: r_text_attr <= i_cfg_data;
                REG_CLEAR_FG:  r_clear_fg  <= i_cfg_data[FG_W-1:0];
            endcase
        end
    end

    assign cfg.text_attr  = r_text_attr;
    assign cfg.clear_fg   = r_clear_fg;

    assign cmd.action     = t_action'(s_axis_tuser);
    assign cmd.char_code  = s_axis_tdata[7:0];
    assign cmd.target_row = s_axis_tdata[12:8];
    assign cmd.target_col = s_axis_tdata[19:13];
    assign cmd.cell_index = s_axis_tdata[30:20];

    tcw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (seq_ready),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = seq_ready && i_rst_n;
    assign m_axis_tvalid = res_valid && i_rst_n;
    assign m_axis_tdata  = res;

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
// Port-level assertions for the text console writer and the bind that attaches them.
`default_nettype none

module tcw_checker import tcw_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata
);

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] < ROWS) && (m_axis_tdata[11:5] < COLUMNS))
        else $error("cursor outside the screen");

    a_cursor_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[22:12] == linear_index(m_axis_tdata[4:0], m_axis_tdata[11:5]))
        else $error("cursor index does not match row and column");

    // A scroll always leaves the cursor at the start of the last row.
    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[39] |->
            (m_axis_tdata[4:0] == ROW_W'(ROWS - 1)) && (m_axis_tdata[11:5] == '0))
        else $error("scroll left the cursor off the last row start");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a command is in progress");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
